/* src/gks_pkg.sv */
// Shared types, constants and fixed-point helpers for the gaze Kalman smoother.
// No dependencies; every other file imports this package.
package gks_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 20;
   localparam int VAR_W     = 18;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam int ONE_FX  = 1 << FRAC_BITS;
   localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
   localparam int VAR_MAX = 2 ** VAR_W - 1;

   // serial gain: quotient digits, operand widths
   localparam int QB      = FRAC_BITS + 1;
   localparam int CNT_W   = $clog2(QB);
   localparam int INNOV_W = POS_W + 1;
   localparam int DEN_W   = VAR_W + 1;
   localparam int NUM_W   = VAR_W + FRAC_BITS + 1;
   localparam int PROD_W  = INNOV_W + QB;
   localparam int RND_W   = PROD_W - FRAC_BITS + 1;
   localparam int SUM_W   = RND_W + 1;
   localparam int CMP_W   = ((POS_W > FRAC_BITS + 2) ? POS_W : FRAC_BITS + 2) + 1;

   localparam logic signed [POS_W-1:0] POS_RESET =
      POS_W'((ONE_FX / 2 > POS_MAX) ? POS_MAX : ONE_FX / 2);
   localparam logic [VAR_W-1:0] VAR_RESET =
      VAR_W'((ONE_FX > VAR_MAX) ? VAR_MAX : ONE_FX);
   localparam logic [QB-1:0] GAIN_ONE = QB'(ONE_FX);
   localparam logic [QB-1:0] C_POINT3 = QB'((3 * ONE_FX + 5) / 10);

   localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET     = CFG_W'(655);
   localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = CFG_W'(6554);
   localparam logic [CFG_W-1:0] OFFSCREEN_MARGIN_RESET  = CFG_W'(13107);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROCESS_NOISE     = 2'd0,
      CSR_MEASUREMENT_NOISE = 2'd1,
      CSR_OFFSCREEN_MARGIN  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      DIR_NONE    = 3'd0,
      DIR_LEFT    = 3'd1,
      DIR_RIGHT   = 3'd2,
      DIR_UP      = 3'd3,
      DIR_DOWN    = 3'd4,
      DIR_UNKNOWN = 3'd5
   } dir_type;

   typedef struct packed {
      logic predict;
      logic prepare;
      logic div_load;
      logic div_step;
      logic mul_load;
      logic mul_step;
      logic commit;
   } lane_ctrl_type;

   // floor((p + 2^(F-1)) / 2^F)
   function automatic logic signed [RND_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] t;
      t = (PROD_W + 1)'(p) + (PROD_W + 1)'(ONE_FX / 2);
      return t[PROD_W:FRAC_BITS];
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_pos(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(POS_MAX);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return POS_W'(POS_MAX);
      end else if (v < lo) begin
         return lo[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

   function automatic logic [VAR_W-1:0] clamp_var(
      input logic signed [RND_W-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > RND_W'(VAR_MAX)) begin
         return VAR_W'(VAR_MAX);
      end
      return v[VAR_W-1:0];
   endfunction

endpackage

/* src/gks_channels.sv */
// Valid/ready channel interfaces for gaze samples in and smoothed points out.
// Depends on gks_pkg for field widths.
interface gks_req_if import gks_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    landmarks_ok;
   logic signed [POS_W-1:0] measured_x;
   logic signed [POS_W-1:0] measured_y;

   modport source (output valid, landmarks_ok, measured_x, measured_y, input ready);
   modport sink (input valid, landmarks_ok, measured_x, measured_y, output ready);
endinterface

interface gks_rsp_if import gks_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] smooth_x;
   logic signed [POS_W-1:0] smooth_y;
   logic                    off_screen;
   logic [2:0]              direction;

   modport source (output valid, smooth_x, smooth_y, off_screen, direction, input ready);
   modport sink (input valid, smooth_x, smooth_y, off_screen, direction, output ready);
endinterface

/* src/gks_serial_div.sv */
// Restoring divider, one quotient bit per step: (var*2^F + den/2) / den.
// Depends on gks_pkg.
module gks_serial_div import gks_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [VAR_W-1:0] var_val,
   input  logic [DEN_W-1:0] den,
   output logic [QB-1:0]    quotient
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QB-1:0]    num_ff, num_in;
   logic [QB-1:0]    quo_ff, quo_in;
   logic [NUM_W-1:0] numer;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      numer = NUM_W'({var_val, {FRAC_BITS{1'b0}}}) + NUM_W'(den >> 1);
      trial = {rem_ff, num_ff[QB-1]};
      diff  = trial - {1'b0, den};
      fits  = trial >= {1'b0, den};
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      if (load) begin
         // top part is below den, so the quotient fits QB bits
         rem_in = DEN_W'(numer >> QB);
         num_in = numer[QB-1:0];
      end else if (step) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in = {num_ff[QB-2:0], 1'b0};
         quo_in = {quo_ff[QB-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

/* src/gks_serial_mul.sv */
// Shift-add multiplier, one multiplier bit per step, LSB first.
// Signed multiplicand times unsigned multiplier; depends on gks_pkg.
module gks_serial_mul import gks_pkg::*; (
   input  logic                      clock,
   input  logic                      load,
   input  logic                      step,
   input  logic signed [INNOV_W-1:0] mcand,
   input  logic [QB-1:0]             mplier,
   output logic signed [PROD_W-1:0]  product
);

   logic signed [INNOV_W-1:0] mcand_ff, mcand_in;
   logic [QB-1:0]             mplier_ff, mplier_in;
   logic signed [INNOV_W-1:0] hi_ff, hi_in;
   logic [QB-1:0]             lo_ff, lo_in;
   logic signed [INNOV_W:0]   psum;

   always_comb begin
      psum = (INNOV_W + 1)'(hi_ff)
           + (mplier_ff[0] ? (INNOV_W + 1)'(mcand_ff) : '0);
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (load) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         hi_in     = '0;
         lo_in     = '0;
      end else if (step) begin
         // low product bits leave through the bottom of the accumulator
         hi_in     = psum[INNOV_W:1];
         lo_in     = {psum[0], lo_ff[QB-1:1]};
         mplier_in = mplier_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
   end

   assign product = {hi_ff, lo_ff};

endmodule

/* src/gks_axis_lane.sv */
// One axis of the smoother: predict, serial gain division, serial products, update.
// Depends on gks_pkg, gks_serial_div and gks_serial_mul.
module gks_axis_lane import gks_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lane_ctrl_type           ctrl,
   input  logic signed [POS_W-1:0] meas,
   input  logic [CFG_W-1:0]        process_noise,
   input  logic [CFG_W-1:0]        measurement_noise,
   output logic signed [POS_W-1:0] pos
);

   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [POS_W-1:0]   vel_ff, vel_in;
   logic [VAR_W-1:0]          var_ff, var_in;
   logic signed [POS_W-1:0]   p_ff, p_in;
   logic [VAR_W-1:0]          v_ff, v_in;
   logic signed [INNOV_W-1:0] innov_ff, innov_in;
   logic [DEN_W-1:0]          den_ff, den_in;

   logic [VAR_W:0]            vsum;
   logic [QB-1:0]             quotient;
   logic [QB-1:0]             gain;
   logic [QB-1:0]             rest;
   logic signed [INNOV_W-1:0] var_mcand;
   logic signed [PROD_W-1:0]  prod_gain, prod_vel, prod_var;

   always_comb begin
      vsum = (VAR_W + 1)'(var_ff) + (VAR_W + 1)'(process_noise);
      p_in = ctrl.predict ? clamp_pos(SUM_W'(pos_ff) + SUM_W'(vel_ff)) : p_ff;
      v_in = v_ff;
      if (ctrl.predict) begin
         v_in = (vsum > (VAR_W + 1)'(VAR_MAX)) ? VAR_W'(VAR_MAX) : vsum[VAR_W-1:0];
      end
      innov_in = ctrl.prepare ? INNOV_W'(meas) - INNOV_W'(p_ff) : innov_ff;
      den_in   = ctrl.prepare ? DEN_W'(v_ff) + DEN_W'(measurement_noise) : den_ff;

      // zero denominator only with a zero noise register; gain is then one
      gain = ((den_ff == '0) || (quotient > GAIN_ONE)) ? GAIN_ONE : quotient;
      rest = GAIN_ONE - gain;
      var_mcand = INNOV_W'(v_ff);

      pos_in = pos_ff;
      vel_in = vel_ff;
      var_in = var_ff;
      if (ctrl.commit) begin
         pos_in = clamp_pos(SUM_W'(p_ff) + SUM_W'(round_shift(prod_gain)));
         vel_in = clamp_pos(SUM_W'(round_shift(prod_vel)));
         var_in = clamp_var(round_shift(prod_var));
      end
   end

   gks_serial_div u_div (
      .clock    (clock),
      .load     (ctrl.div_load),
      .step     (ctrl.div_step),
      .var_val  (v_ff),
      .den      (den_ff),
      .quotient (quotient)
   );

   gks_serial_mul u_mul_gain (
      .clock   (clock),
      .load    (ctrl.mul_load),
      .step    (ctrl.mul_step),
      .mcand   (innov_ff),
      .mplier  (gain),
      .product (prod_gain)
   );

   gks_serial_mul u_mul_vel (
      .clock   (clock),
      .load    (ctrl.mul_load),
      .step    (ctrl.mul_step),
      .mcand   (innov_ff),
      .mplier  (C_POINT3),
      .product (prod_vel)
   );

   gks_serial_mul u_mul_var (
      .clock   (clock),
      .load    (ctrl.mul_load),
      .step    (ctrl.mul_step),
      .mcand   (var_mcand),
      .mplier  (rest),
      .product (prod_var)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_RESET;
         vel_ff <= '0;
         var_ff <= VAR_RESET;
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         var_ff <= var_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      v_ff     <= v_in;
      innov_ff <= innov_in;
      den_ff   <= den_in;
   end

   assign pos = pos_ff;

endmodule

/* src/gaze_kalman_smoother_core.sv */
// Gaze smoother top: two axis lanes run side by side under one sequencer.
// With landmarks: predict, prepare, divider load, divider steps, multiplier load,
// multiplier steps, update, done; without landmarks straight to done. A new sample
// is taken only in idle, so each lane's serial divider and multipliers set throughput.
// Reset (synchronous) restores filter state and registers at once; no clearing pass.
// Depends on gks_pkg, gks_channels and gks_axis_lane.
module gaze_kalman_smoother_core import gks_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   gks_req_if.sink              req_if,
   gks_rsp_if.source            rsp_if,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PRED  = 9'b000000010,
      ST_PREP  = 9'b000000100,
      ST_DIVLD = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_MULLD = 9'b000100000,
      ST_MUL   = 9'b001000000,
      ST_UPD   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    bypass_ff, bypass_in;
   logic signed [POS_W-1:0] meas_x_ff, meas_x_in;
   logic signed [POS_W-1:0] meas_y_ff, meas_y_in;
   logic [CFG_W-1:0]        pn_ff, pn_in;
   logic [CFG_W-1:0]        mn_ff, mn_in;
   logic [CFG_W-1:0]        om_ff, om_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [POS_W-1:0] rsp_y_ff, rsp_y_in;
   logic                    rsp_off_ff, rsp_off_in;
   dir_type                 rsp_dir_ff, rsp_dir_in;

   lane_ctrl_type           ctrl;
   logic signed [POS_W-1:0] pos_x, pos_y;
   logic                    req_accept;
   logic                    out_free;
   logic signed [CMP_W-1:0] sx, sy, lo_bound, hi_bound, one_c;
   logic                    outside;
   dir_type                 dir;

   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      ctrl.predict  = state_ff == ST_PRED;
      ctrl.prepare  = state_ff == ST_PREP;
      ctrl.div_load = state_ff == ST_DIVLD;
      ctrl.div_step = state_ff == ST_DIV;
      ctrl.mul_load = state_ff == ST_MULLD;
      ctrl.mul_step = state_ff == ST_MUL;
      ctrl.commit   = state_ff == ST_UPD;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      bypass_in = bypass_ff;
      meas_x_in = meas_x_ff;
      meas_y_in = meas_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               meas_x_in = req_if.measured_x;
               meas_y_in = req_if.measured_y;
               bypass_in = !req_if.landmarks_ok;
               state_in  = req_if.landmarks_ok ? ST_PRED : ST_DONE;
            end
         end
         ST_PRED:  state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIVLD;
         ST_DIVLD: begin
            cnt_in   = CNT_W'(QB - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_MULLD;
            end
         end
         ST_MULLD: begin
            cnt_in   = CNT_W'(QB - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pn_in = pn_ff;
      mn_in = mn_ff;
      om_in = om_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     pn_in = csr_write_data;
            CSR_MEASUREMENT_NOISE: mn_in = csr_write_data;
            CSR_OFFSCREEN_MARGIN:  om_in = csr_write_data;
            default: ;
         endcase
      end
   end

   gks_axis_lane u_lane_x (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .meas              (meas_x_ff),
      .process_noise     (pn_ff),
      .measurement_noise (mn_ff),
      .pos               (pos_x)
   );

   gks_axis_lane u_lane_y (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .meas              (meas_y_ff),
      .process_noise     (pn_ff),
      .measurement_noise (mn_ff),
      .pos               (pos_y)
   );

   // off-screen test uses the widened box, direction the plain unit box
   always_comb begin
      sx       = CMP_W'(pos_x);
      sy       = CMP_W'(pos_y);
      one_c    = CMP_W'(ONE_FX);
      lo_bound = -CMP_W'(om_ff);
      hi_bound = one_c + CMP_W'(om_ff);
      outside  = (sx < lo_bound) || (sx > hi_bound) || (sy < lo_bound) || (sy > hi_bound);
      priority if (!outside) begin
         dir = DIR_NONE;
      end else if (sx < 0) begin
         dir = DIR_LEFT;
      end else if (sx > one_c) begin
         dir = DIR_RIGHT;
      end else if (sy < 0) begin
         dir = DIR_UP;
      end else if (sy > one_c) begin
         dir = DIR_DOWN;
      end else begin
         dir = DIR_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_dir_in   = rsp_dir_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         if (bypass_ff) begin
            rsp_x_in   = POS_RESET;
            rsp_y_in   = POS_RESET;
            rsp_off_in = 1'b1;
            rsp_dir_in = DIR_UNKNOWN;
         end else begin
            rsp_x_in   = pos_x;
            rsp_y_in   = pos_y;
            rsp_off_in = outside;
            rsp_dir_in = dir;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bypass_ff    <= 1'b0;
         pn_ff        <= PROCESS_NOISE_RESET;
         mn_ff        <= MEASUREMENT_NOISE_RESET;
         om_ff        <= OFFSCREEN_MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bypass_ff    <= bypass_in;
         pn_ff        <= pn_in;
         mn_ff        <= mn_in;
         om_ff        <= om_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_x_ff  <= meas_x_in;
      meas_y_ff  <= meas_y_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_off_ff <= rsp_off_in;
      rsp_dir_ff <= rsp_dir_in;
   end

   assign req_if.ready      = state_ff == ST_IDLE;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.smooth_x   = rsp_x_ff;
   assign rsp_if.smooth_y   = rsp_y_ff;
   assign rsp_if.off_screen = rsp_off_ff;
   assign rsp_if.direction  = rsp_dir_ff;

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_no_landmarks_skips: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_if.landmarks_ok |=> state_ff == ST_DONE)
      else $error("transaction without landmarks entered the filter");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_MUL) |-> cnt_ff <= CNT_W'(QB - 1))
      else $error("digit counter out of range");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the done state");

   a_dir_implies_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dir_ff != DIR_NONE |-> rsp_off_ff)
      else $error("direction reported for an on-screen point");
`endif

endmodule

/* test/testbench.sv */
// Self-checking bench for gaze_kalman_smoother_core: a cycle-free filter predictor,
// random handshake stalls on both channels and field-by-field result checks.
// Depends on gks_pkg, gks_channels and the core itself; nothing else.
module testbench;
   import gks_pkg::*;

   localparam longint POS_LO        = -longint'(POS_MAX) - 1;
   localparam longint CENTRE_FX     = ONE_FX / 2;
   localparam longint VEL_COEF      = (3 * ONE_FX + 5) / 10;
   localparam int     SETTLE_CYCLES = 50;
   localparam int     WATCHDOG_MAX  = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = CSR_IDX_W'(3);
   localparam logic [CFG_W-1:0]     CFG_TOP         = '1;

   typedef struct {
      longint pos;
      longint vel;
      longint variance;
   } axis_state_type;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic                    off;
      dir_type                 dir;
   } gaze_point_type;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   gks_req_if req_ch ();
   gks_rsp_if rsp_ch ();

   gaze_kalman_smoother_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state and register shadow
   axis_state_type axis_x;
   axis_state_type axis_y;
   longint         cfg_q_noise;
   longint         cfg_r_noise;
   longint         cfg_margin;

   gaze_point_type pending[$];
   int             mismatches = 0;
   int             idle_cycles = 0;
   bit             steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // product back to F fraction bits, round half up (arithmetic shift floors)
   function automatic longint fx_round(input longint p);
      return (p + ONE_FX / 2) >>> FRAC_BITS;
   endfunction

   function automatic axis_state_type filter_axis(input axis_state_type s,
                                                  input longint meas);
      axis_state_type n;
      longint p, v, innov, den, gain;
      p     = saturate(s.pos + s.vel, POS_LO, POS_MAX);
      v     = saturate(s.variance + cfg_q_noise, 0, VAR_MAX);
      innov = meas - p;
      den   = v + cfg_r_noise;
      gain  = (den == 0) ? longint'(ONE_FX) : (v * ONE_FX + den / 2) / den;
      if (gain > ONE_FX) begin
         gain = ONE_FX;
      end
      n.pos      = saturate(p + fx_round(gain * innov), POS_LO, POS_MAX);
      n.vel      = saturate(fx_round(innov * VEL_COEF), POS_LO, POS_MAX);
      n.variance = saturate(fx_round(v * (ONE_FX - gain)), 0, VAR_MAX);
      return n;
   endfunction

   function automatic gaze_point_type predict_point(input logic ok, input longint mx,
                                                    input longint my);
      gaze_point_type pt;
      longint sx, sy;
      pt.off = 1'b0;
      pt.dir = DIR_NONE;
      if (!ok) begin
         // no face: fixed centre, filter state untouched
         pt.x   = POS_W'(CENTRE_FX);
         pt.y   = POS_W'(CENTRE_FX);
         pt.off = 1'b1;
         pt.dir = DIR_UNKNOWN;
         return pt;
      end
      axis_x = filter_axis(axis_x, mx);
      axis_y = filter_axis(axis_y, my);
      sx = axis_x.pos;
      sy = axis_y.pos;
      pt.x = POS_W'(sx);
      pt.y = POS_W'(sy);
      if (sx < -cfg_margin || sx > ONE_FX + cfg_margin ||
          sy < -cfg_margin || sy > ONE_FX + cfg_margin) begin
         pt.off = 1'b1;
         // direction is judged against the bare unit box
         if (sx < 0) begin
            pt.dir = DIR_LEFT;
         end else if (sx > ONE_FX) begin
            pt.dir = DIR_RIGHT;
         end else if (sy < 0) begin
            pt.dir = DIR_UP;
         end else if (sy > ONE_FX) begin
            pt.dir = DIR_DOWN;
         end
      end
      return pt;
   endfunction

   task automatic check_field(input string what, input logic signed [POS_W-1:0] want_v,
                              input logic signed [POS_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   // monitor: register shadow, prediction on accept, checks on result, watchdog
   always @(posedge clock) begin
      gaze_point_type want;
      gaze_point_type pred;
      if (reset) begin
         axis_x      = '{pos: CENTRE_FX, vel: 0, variance: saturate(ONE_FX, 0, VAR_MAX)};
         axis_y      = axis_x;
         cfg_q_noise = 655;
         cfg_r_noise = 6554;
         cfg_margin  = 13107;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PROCESS_NOISE:     cfg_q_noise = longint'(csr_write_data);
               CSR_MEASUREMENT_NOISE: cfg_r_noise = longint'(csr_write_data);
               CSR_OFFSCREEN_MARGIN:  cfg_margin  = longint'(csr_write_data);
               default: ;
            endcase
         end
         // result side first so a result can never match its own request edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending.size() == 0) begin
               $display("%0t: unexpected result x=%0d y=%0d", $time,
                        rsp_ch.smooth_x, rsp_ch.smooth_y);
               mismatches++;
            end else begin
               want = pending.pop_front();
               check_field("smooth_x", want.x, rsp_ch.smooth_x);
               check_field("smooth_y", want.y, rsp_ch.smooth_y);
               check_field("off_screen", POS_W'(want.off), POS_W'(rsp_ch.off_screen));
               check_field("direction", POS_W'(want.dir), POS_W'(rsp_ch.direction));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pred = predict_point(req_ch.landmarks_ok,
                                 longint'(req_ch.measured_x),
                                 longint'(req_ch.measured_y));
            pending.insert(pending.size(), pred);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
               $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   // result sink with random back-pressure
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // valid stays high on return so a back-to-back transaction needs no toggle
   task automatic send_sample(input logic ok, input logic signed [POS_W-1:0] mx,
                              input logic signed [POS_W-1:0] my);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.landmarks_ok <= ok;
      req_ch.measured_x   <= mx;
      req_ch.measured_y   <= my;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_results();
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      req_ch.valid <= 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // also pokes the unused index, which must leave everything alone
   task automatic configure(input logic [CFG_W-1:0] q_noise, input logic [CFG_W-1:0] r_noise,
                            input logic [CFG_W-1:0] margin);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PROCESS_NOISE;
      csr_write_data   <= q_noise;
      @(posedge clock);
      csr_index        <= CSR_MEASUREMENT_NOISE;
      csr_write_data   <= r_noise;
      @(posedge clock);
      csr_index        <= CSR_OFFSCREEN_MARGIN;
      csr_write_data   <= margin;
      @(posedge clock);
      csr_index        <= CSR_SPARE_INDEX;
      csr_write_data   <= CFG_W'($urandom());
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_setting(input int low);
      int k;
      k = $urandom_range(0, 3);
      case (k)
         0:       return CFG_W'(low);
         1:       return CFG_TOP;
         default: return CFG_W'($urandom_range(low, 65535));
      endcase
   endfunction

   // reset register values: missing landmarks, centre, each edge of the screen
   task automatic test_directed_extremes();
      logic signed [POS_W-1:0] mid, lo, hi;
      mid = POS_W'(CENTRE_FX);
      lo  = POS_W'(POS_LO);
      hi  = POS_W'(POS_MAX);
      send_sample(1'b0, hi, lo);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, lo, mid);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, hi, mid);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, mid, lo);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, mid, hi);
      send_sample(1'b1, mid, mid);
      send_sample(1'b1, lo, hi);
      send_sample(1'b0, '0, '0);
   endtask

   // zero noise with zero measurement noise drives the gain denominator to zero
   task automatic test_register_extremes();
      settle_block();
      configure('0, '0, '0);
      send_sample(1'b1, POS_W'(ONE_FX), '0);
      send_sample(1'b1, '0, POS_W'(ONE_FX));
      send_sample(1'b1, POS_W'(POS_MAX), POS_W'(POS_LO));
      settle_block();
      configure(CFG_TOP, CFG_TOP, CFG_TOP);
      send_sample(1'b1, POS_W'(POS_LO), POS_W'(POS_MAX));
      send_sample(1'b1, POS_W'(-ONE_FX), POS_W'(2 * ONE_FX));
      settle_block();
      configure('0, CFG_W'(1), '0);
      send_sample(1'b1, POS_W'(ONE_FX + 1), POS_W'(-1));
      send_sample(1'b1, POS_W'(CENTRE_FX), POS_W'(CENTRE_FX));
   endtask

   // fixations with sensor noise, occasional saccades, junk frames and lost faces
   task automatic test_random_traffic();
      logic signed [POS_W-1:0] mx, my;
      longint target_x, target_y;
      int kind;
      target_x = CENTRE_FX;
      target_y = CENTRE_FX;
      for (int phase = 0; phase < 5; phase++) begin
         settle_block();
         configure(pick_setting(0), pick_setting(1), pick_setting(0));
         steady = (phase == 2);
         for (int n = 0; n < 280; n++) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) begin
               target_x = longint'($urandom_range(0, 2 * ONE_FX)) - ONE_FX / 2;
               target_y = longint'($urandom_range(0, 2 * ONE_FX)) - ONE_FX / 2;
            end
            if (kind < 3) begin
               mx = POS_W'($urandom());
               my = POS_W'($urandom());
            end else begin
               mx = POS_W'(target_x + longint'($urandom_range(0, 6554)) - 3277);
               my = POS_W'(target_y + longint'($urandom_range(0, 6554)) - 3277);
            end
            send_sample(kind != 0, mx, my);
            if ($urandom_range(0, 63) == 0) begin
               req_ch.valid <= 1'b0;
               wait_for_results();
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.landmarks_ok <= 1'b0;
      req_ch.measured_x   <= '0;
      req_ch.measured_y   <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_PROCESS_NOISE;
      csr_write_data      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_register_extremes();
      test_random_traffic();
      settle_block();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
